// ===== design/cbnc_pkg.sv =====
// Shared types, constants and bucketing functions for the coverage bitmap
// novelty checker. No dependencies; used by the top, the checker and the bench.
package cbnc_pkg;

  // Map geometry
  localparam int unsigned MAP_WORDS = 65536;
  localparam int unsigned ADDR_W    = $clog2(MAP_WORDS);
  localparam int unsigned IDX_W     = 16;
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned NBYTES    = WORD_W / 8;

  // A virgin byte that has never seen any hit class
  localparam logic [7:0] BYTE_PRISTINE = 8'hff;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [1:0]        novelty_t;

  // Novelty verdict codes (ordered: higher means more interesting)
  localparam novelty_t NOV_NONE  = 2'd0;
  localparam novelty_t NOV_HITS  = 2'd1;
  localparam novelty_t NOV_EDGES = 2'd2;

  typedef struct packed {
    logic [IDX_W-1:0]  word_index;
    logic [WORD_W-1:0] trace_word;
    logic              last_word;
  } in_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] classified_word;
    novelty_t          novelty;
    logic              run_done;
  } out_word_t;

  // Power-of-two hit-count class of one raw byte counter
  function automatic logic [7:0] bucket_byte(input logic [7:0] b);
    logic [7:0] r;
    priority if (b == 8'd0)   r = 8'd0;
    else if (b == 8'd1)       r = 8'd1;
    else if (b == 8'd2)       r = 8'd2;
    else if (b == 8'd3)       r = 8'd4;
    else if (b < 8'd8)        r = 8'd8;
    else if (b < 8'd16)       r = 8'd16;
    else if (b < 8'd32)       r = 8'd32;
    else if (b < 8'd128)      r = 8'd64;
    else                      r = 8'd128;
    return r;
  endfunction

  // Bucket all eight byte lanes independently
  function automatic logic [WORD_W-1:0] classify_word(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] r;
    r = '0;
    for (int k = 0; k < NBYTES; k++) begin
      r[8*k +: 8] = bucket_byte(w[8*k +: 8]);
    end
    return r;
  endfunction

  // Word index to map address; wraps modulo the map size
  function automatic addr_t map_addr(input logic [IDX_W-1:0] wi);
    logic [IDX_W+ADDR_W-1:0] ext;
    ext = {{ADDR_W{1'b0}}, wi};
    return ext[ADDR_W-1:0];
  endfunction

endpackage

// ===== design/cbnc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Read-first: a read and write to the same address in one cycle returns old data.
module cbnc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/coverage_bitmap_novelty_check_top.sv =====
// Coverage bitmap novelty checker: buckets each 64-bit hit-count word into
// power-of-two classes and tests it against the virgin map.
// Depends on cbnc_pkg and cbnc_ram.
//
// Usage: after reset the block sweeps the virgin map to all ones, one word a
// cycle, over all MAP_WORDS words; in_ready_o stays low until the sweep
// ends. From then on it takes one word per cycle with no bubbles while the
// receiver keeps taking results; a word is held in the compare stage and its
// result is registered when it moves on into the result register, once that
// register is free. The rate is set by the single read-modify-write of the
// virgin map per word: the map RAM is read when a word is accepted and
// written back when that word moves into the result register, with a bypass
// so back-to-back words to the same index see the updated value. The running
// novelty clears after the word flagged last_word.
module coverage_bitmap_novelty_check_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cbnc_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cbnc_pkg::out_word_t out_word_o
);

  // Clear sweep
  logic                clr_busy_q;
  cbnc_pkg::addr_t     clr_addr_q;

  // Compare stage
  logic                               s1_valid_q;
  logic [cbnc_pkg::WORD_W-1:0]        s1_cls_q;
  cbnc_pkg::addr_t                    s1_addr_q;
  logic                               s1_last_q;
  logic                               fwd_hit_q;
  logic [cbnc_pkg::WORD_W-1:0]        fwd_data_q;

  // Result register and run state
  logic                out_valid_q;
  cbnc_pkg::out_word_t out_word_q;
  cbnc_pkg::novelty_t  run_nov_q;

  logic                          s1_adv;
  logic                          in_acc;
  cbnc_pkg::addr_t               in_addr;
  logic [cbnc_pkg::WORD_W-1:0]   in_cls;
  logic [cbnc_pkg::WORD_W-1:0]   ram_rdata;
  logic [cbnc_pkg::WORD_W-1:0]   s1_vir;
  logic [cbnc_pkg::WORD_W-1:0]   s1_new;
  logic                          overlap;
  logic                          pristine;
  cbnc_pkg::novelty_t            level;
  cbnc_pkg::novelty_t            nov_max;
  logic                          ram_we;
  cbnc_pkg::addr_t               ram_waddr;
  logic [cbnc_pkg::WORD_W-1:0]   ram_wdata;

  // Handshake
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clr_busy_q && (!s1_valid_q || s1_adv);
  assign in_acc     = in_valid_i && in_ready_o;

  // Input side: address wrap and bucketing
  assign in_addr = cbnc_pkg::map_addr(in_word_i.word_index);
  assign in_cls  = cbnc_pkg::classify_word(in_word_i.trace_word);

  // Virgin word, bypassing a write-back to the same address
  assign s1_vir  = fwd_hit_q ? fwd_data_q : ram_rdata;
  assign s1_new  = s1_vir & ~s1_cls_q;
  assign overlap = |(s1_cls_q & s1_vir);

  // Nonzero class landing on a pristine virgin byte
  always_comb begin
    pristine = 1'b0;
    for (int k = 0; k < cbnc_pkg::NBYTES; k++) begin
      if ((s1_cls_q[8*k +: 8] != 8'd0) && (s1_vir[8*k +: 8] == cbnc_pkg::BYTE_PRISTINE)) begin
        pristine = 1'b1;
      end
    end
  end

  // Novelty level for this word, merged into the run maximum
  always_comb begin
    priority if (!overlap) level = cbnc_pkg::NOV_NONE;
    else if (pristine)     level = cbnc_pkg::NOV_EDGES;
    else                   level = cbnc_pkg::NOV_HITS;
    nov_max = (level > run_nov_q) ? level : run_nov_q;
  end

  // Map write port: clear sweep or write-back (no-overlap write is a no-op)
  assign ram_we    = clr_busy_q || s1_adv;
  assign ram_waddr = clr_busy_q ? clr_addr_q : s1_addr_q;
  assign ram_wdata = clr_busy_q ? {cbnc_pkg::WORD_W{1'b1}} : s1_new;

  cbnc_ram #(
    .WIDTH (cbnc_pkg::WORD_W),
    .DEPTH (cbnc_pkg::MAP_WORDS)
  ) u_virgin_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  // Clear sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == cbnc_pkg::addr_t'(cbnc_pkg::MAP_WORDS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Compare stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Compare stage payload and bypass capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cls_q   <= in_cls;
      s1_addr_q  <= in_addr;
      s1_last_q  <= in_word_i.last_word;
      fwd_hit_q  <= s1_adv && (s1_addr_q == in_addr);
      fwd_data_q <= s1_new;
    end
  end

  // Result register and running novelty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      run_nov_q   <= cbnc_pkg::NOV_NONE;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
      run_nov_q   <= s1_last_q ? cbnc_pkg::NOV_NONE : nov_max;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_word_q.classified_word <= s1_cls_q;
      out_word_q.novelty         <= nov_max;
      out_word_q.run_done        <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ===== design/cbnc_checker.sv =====
// Port-level checks for the coverage bitmap novelty checker, bound to the top.
// Depends on cbnc_pkg.
module cbnc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input cbnc_pkg::in_word_t  in_word_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input cbnc_pkg::out_word_t out_word_o
);

  logic               out_acc;
  logic               prev_done_q;
  cbnc_pkg::novelty_t prev_nov_q;

  assign out_acc = out_valid_o && out_ready_i;

  // Track the previous delivered word of the current run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_done_q <= 1'b1;
      prev_nov_q  <= cbnc_pkg::NOV_NONE;
    end else if (out_acc) begin
      prev_done_q <= out_word_o.run_done;
      prev_nov_q  <= out_word_o.novelty;
    end
  end

  // An offered input word holds until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_word_i))
    else $error("input word changed or dropped while waiting");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed or dropped while stalled");

  // Novelty never takes the unused code
  a_nov_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.novelty == cbnc_pkg::NOV_NONE ||
                     out_word_o.novelty == cbnc_pkg::NOV_HITS ||
                     out_word_o.novelty == cbnc_pkg::NOV_EDGES))
    else $error("novelty out of range");

  // Every classified byte is zero or a single power of two
  a_cls_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($onehot0(out_word_o.classified_word[7:0])   &&
                     $onehot0(out_word_o.classified_word[15:8])  &&
                     $onehot0(out_word_o.classified_word[23:16]) &&
                     $onehot0(out_word_o.classified_word[31:24]) &&
                     $onehot0(out_word_o.classified_word[39:32]) &&
                     $onehot0(out_word_o.classified_word[47:40]) &&
                     $onehot0(out_word_o.classified_word[55:48]) &&
                     $onehot0(out_word_o.classified_word[63:56])))
    else $error("classified byte is not a single class");

  // Within a run the novelty verdict never falls
  a_nov_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !prev_done_q |-> out_word_o.novelty >= prev_nov_q)
    else $error("novelty decreased within a run");

endmodule

bind coverage_bitmap_novelty_check_top cbnc_checker u_cbnc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);

// ===== bench/testbench.sv =====
// Self-checking bench for coverage_bitmap_novelty_check_top: drives map words
// over valid/ready with random gaps and checks each result against a predictor.
// Depends on cbnc_pkg and the RTL in design/.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_CYCLES = 1000000;
  localparam int unsigned RANDOM_WORDS = 1100;
  localparam int unsigned MAX_REPORTS  = 60;

  // Predicts every result from accepted words and checks results in order
  class novelty_scoreboard;
    logic [cbnc_pkg::WORD_W-1:0] vir_shadow [int unsigned];
    cbnc_pkg::novelty_t          run_level;
    cbnc_pkg::out_word_t         expected_q [$];
    int unsigned                 errors;
    int unsigned                 reports;
    int unsigned                 checked;
    int unsigned                 runs_closed;
    int unsigned                 level_count [3];

    function new();
      run_level = cbnc_pkg::NOV_NONE;
      errors    = 0;
      reports   = 0;
      checked   = 0;
      runs_closed = 0;
      level_count = '{0, 0, 0};
    endfunction

    // Hit-count class of one counter, by its highest set bit
    function logic [7:0] hit_class(logic [7:0] b);
      logic [7:0] c;
      casez (b)
        8'b1???????: c = 8'd128;
        8'b01??????: c = 8'd64;
        8'b001?????: c = 8'd64;
        8'b0001????: c = 8'd32;
        8'b00001???: c = 8'd16;
        8'b000001??: c = 8'd8;
        8'b00000011: c = 8'd4;
        8'b00000010: c = 8'd2;
        8'b00000001: c = 8'd1;
        default:     c = 8'd0;
      endcase
      return c;
    endfunction

    // Note an accepted word: update the virgin map and queue its result
    function void note_word(cbnc_pkg::in_word_t w);
      int unsigned                 a;
      logic [cbnc_pkg::WORD_W-1:0] cls;
      logic [cbnc_pkg::WORD_W-1:0] vir;
      bit                          fresh;
      cbnc_pkg::out_word_t         r;
      a     = int'(w.word_index) % cbnc_pkg::MAP_WORDS;
      fresh = 1'b0;
      for (int k = 0; k < cbnc_pkg::NBYTES; k++) begin
        cls[8*k +: 8] = hit_class(w.trace_word[8*k +: 8]);
      end
      vir = vir_shadow.exists(a) ? vir_shadow[a] : '1;
      if ((cls & vir) != '0) begin
        // A nonzero class landing on an untouched virgin byte is a new edge
        for (int k = 0; k < cbnc_pkg::NBYTES; k++) begin
          if (cls[8*k +: 8] != 8'd0 && vir[8*k +: 8] == cbnc_pkg::BYTE_PRISTINE)
            fresh = 1'b1;
        end
        if (fresh && run_level != cbnc_pkg::NOV_EDGES) run_level = cbnc_pkg::NOV_EDGES;
        else if (!fresh && run_level == cbnc_pkg::NOV_NONE) run_level = cbnc_pkg::NOV_HITS;
        vir_shadow[a] = vir & ~cls;
      end
      r.classified_word = cls;
      r.novelty         = run_level;
      r.run_done        = w.last_word;
      expected_q.push_back(r);
      if (w.last_word) run_level = cbnc_pkg::NOV_NONE;
    endfunction

    function void flag(string msg);
      errors++;
      if (reports < MAX_REPORTS) $display("%0t: %s", $time, msg);
      else if (reports == MAX_REPORTS) $display("%0t: further mismatches not shown", $time);
      reports++;
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_word(cbnc_pkg::out_word_t got);
      cbnc_pkg::out_word_t e;
      if (expected_q.size() == 0) begin
        flag($sformatf("result with none expected: %h", got));
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (got.classified_word !== e.classified_word)
        flag($sformatf("classified_word expected %h got %h", e.classified_word,
                       got.classified_word));
      if (got.novelty !== e.novelty)
        flag($sformatf("novelty expected %0d got %0d", e.novelty, got.novelty));
      if (got.run_done !== e.run_done)
        flag($sformatf("run_done expected %0d got %0d", e.run_done, got.run_done));
      if (e.novelty <= cbnc_pkg::NOV_EDGES) level_count[e.novelty]++;
      if (e.run_done) runs_closed++;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  cbnc_pkg::in_word_t  in_word = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  cbnc_pkg::out_word_t out_word;

  novelty_scoreboard sb;
  bit          quiet = 1'b0;
  int unsigned stall_left = 0;
  int unsigned stall_pick;
  int unsigned cycles = 0;
  int unsigned words_sent = 0;

  coverage_bitmap_novelty_check_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word)
  );

  always #10 clk_i = ~clk_i;

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Raw counter with a coverage-map-like spread: mostly zero or small
  function automatic logic [7:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 8'd0;
    if (r < 75) return 8'($urandom_range(1, 3));
    if (r < 90) return 8'($urandom_range(4, 31));
    return 8'($urandom_range(32, 255));
  endfunction

  // Receiver stalls
  always @(posedge clk_i) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      stall_pick = pick_gap();
      if (stall_pick > 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_pick - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid === 1'b1 && out_ready) sb.check_word(out_word);
  end

  // Watchdog; also covers the map clearing sweep after reset
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time, sb.pending());
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Offer one word, hold it until accepted, then note it
  task automatic send_word(logic [cbnc_pkg::IDX_W-1:0] idx,
                           logic [cbnc_pkg::WORD_W-1:0] trace, logic last);
    int unsigned gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid           <= 1'b1;
    in_word.word_index <= idx;
    in_word.trace_word <= trace;
    in_word.last_word  <= last;
    do @(posedge clk_i); while (in_ready !== 1'b1);
    sb.note_word(in_word);
    words_sent++;
  endtask

  task automatic random_word(bit noise, logic [cbnc_pkg::IDX_W-1:0] idx, logic last);
    logic [cbnc_pkg::WORD_W-1:0] w;
    if (noise) begin
      w = {$urandom, $urandom};
    end else begin
      for (int k = 0; k < cbnc_pkg::NBYTES; k++) w[8*k +: 8] = pick_count();
    end
    send_word(idx, w, last);
  endtask

  initial begin
    int unsigned len;
    int unsigned base;
    bit          noise_run;
    sb = new();

    // Reset: a real falling edge so the asynchronous reset takes effect
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty word, every bucket edge, repeats with no overlap,
    // weaker novelty on touched bytes, last word clearing, map extremes
    send_word(16'h0000, 64'h0, 1'b1);
    send_word(16'h0000, 64'h0F08_0704_0302_0100, 1'b0);
    send_word(16'h0000, 64'h0F08_0704_0302_0100, 1'b0);
    send_word(16'h0000, 64'h0201_FF80_7F20_1F10, 1'b1);
    send_word(16'h0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_word(16'h0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_word(16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_word(16'hFFFF, 64'h0000_0000_0000_0001, 1'b1);
    send_word(16'hAAAA, 64'h5555_5555_5555_5555, 1'b0);
    send_word(16'h5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_word(16'hAAAA, 64'h0303_0303_0303_0303, 1'b1);
    send_word(16'h0001, 64'h8000_0000_0000_0000, 1'b0);
    send_word(16'h0001, 64'h4000_0000_0000_0000, 1'b1);

    // Random runs: mostly scans of a small index pool so the virgin map
    // wears down, plus full-range noise and runs left without a last word
    while (words_sent < RANDOM_WORDS) begin
      quiet     = ($urandom_range(0, 9) == 0);
      noise_run = ($urandom_range(0, 99) < 15);
      len       = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
      base      = $urandom_range(0, 511);
      for (int unsigned k = 0; k < len; k++) begin
        random_word(noise_run,
                    noise_run ? 16'($urandom) : 16'((base + k) % 512),
                    (k == len - 1) && ($urandom_range(0, 9) != 0));
      end
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("sent %0d words, checked %0d results over %0d closed runs",
             words_sent, sb.checked, sb.runs_closed);
    $display("novelty seen: none %0d, new counts %0d, new edges %0d",
             sb.level_count[0], sb.level_count[1], sb.level_count[2]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
